// File: design/t1be_pkg.sv
// Package for the T=1 block engine: phase codes, actions, destinations, PCB codes and sizes.
// No dependencies.
package t1be_pkg;

	localparam int CMD_DEPTH_DEF = 512;
	localparam int RESP_MAX_DEF  = 259;
	localparam logic [7:0] IFSC_RESET = 8'd32;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'd0,
		PH_TX_I   = 4'd1,
		PH_WAIT_R = 4'd2,
		PH_RX     = 4'd3,
		PH_TX_R   = 4'd4,
		PH_TX_S   = 4'd5,
		PH_WAIT_S = 4'd6
	} phase_t;

	localparam logic [2:0] ACT_CMD     = 3'd0;
	localparam logic [2:0] ACT_CARD    = 3'd1;
	localparam logic [2:0] ACT_TIMEOUT = 3'd2;
	localparam logic [2:0] ACT_IFS     = 3'd3;
	localparam logic [2:0] ACT_RESYNCH = 3'd4;
	localparam logic [2:0] ACT_SLOT    = 3'd5;

	localparam logic [1:0] DEST_CARD = 2'd0;
	localparam logic [1:0] DEST_HOST = 2'd1;
	localparam logic [1:0] DEST_END  = 2'd2;

	localparam logic [7:0] PCB_IFS_REQ   = 8'hC1;
	localparam logic [7:0] PCB_RESYN_REQ = 8'hC0;
	localparam logic [7:0] PCB_WTX_RSP   = 8'hE3;
	localparam logic [7:0] TYPE_R_OK     = 8'h80;
	localparam logic [7:0] TYPE_RESYN_RSP = 8'hE0;
	localparam logic [7:0] TYPE_WTX_REQ  = 8'hC3;
	localparam logic [7:0] TYPE_MASK     = 8'hEF;

endpackage

// File: design/t1be_if.sv
// Valid/ready channel interfaces for the T=1 block engine.
// Depends on nothing; payload widths fixed by the block's fields.
interface t1be_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] data;
	logic       last;
	modport source (output valid, action, data, last, input ready);
	modport sink (input valid, action, data, last, output ready);
endinterface

interface t1be_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] dest;
	logic [7:0] data_res;
	logic       status;
	logic [8:0] resp_count;
	logic       block_end;
	modport source (output valid, dest, data_res, status, resp_count, block_end, input ready);
	modport sink (input valid, dest, data_res, status, resp_count, block_end, output ready);
endinterface

interface t1be_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: design/iso7816_t1_block_engine.sv
// Top level of the card-side T=1 block engine.
// Depends on t1be_pkg and the channel interfaces in t1be_if.sv.
//
// Channel   Direction  Carries
// in_ch     sink       action, data, last
// out_ch    source     dest, data_res, status, resp_count, block_end
// cfg_ch    sink       IFSC write data
//
// Items are accepted one per cycle while input ready is high. A command byte is
// written to the command memory; a transmit slot reads it and the data returns
// in the next cycle in stage 2, where the byte goes out. The state update happens
// in stage 1, so the next item follows at once. Results pass the stage 2
// registers into a four-entry output queue that absorbs result stalls; input
// ready drops only when that queue could overflow. Reset is asynchronous.
module iso7816_t1_block_engine import t1be_pkg::*; #(
	parameter int CMD_DEPTH = CMD_DEPTH_DEF,
	parameter int RESP_MAX  = RESP_MAX_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	t1be_in_if.sink       in_ch,
	t1be_out_if.source    out_ch,
	t1be_cfg_if.sink      cfg_ch
);

	localparam int AW = $clog2(CMD_DEPTH);
	localparam int LW = $clog2(CMD_DEPTH + 1);
	localparam int CW = LW + 1;

	logic [7:0]    mem [CMD_DEPTH];
	logic [7:0]    ifsc_q;
	phase_t        phase_q;
	logic [LW-1:0] cmd_len_q;
	logic [LW-1:0] cmd_sent_q;
	logic          seq_q;
	logic [8:0]    tx_pos_q;
	logic [7:0]    tx_len_q, tx_pcb_q, tx_info_q, tx_lrc_q;
	logic          more_q;
	logic [8:0]    rx_pos_q;
	logic [7:0]    rx_pcb_q, rx_len_q, rx_first_q;
	logic [8:0]    resp_q;

	// Configuration register.
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ifsc_q <= IFSC_RESET;
		end else if (cfg_ch.valid) begin
			ifsc_q <= cfg_ch.data;
		end
	end

	// Output queue occupancy governs input ready.
	logic [2:0] q_cnt_q;
	logic       s2_v;
	logic       acc;
	assign in_ch.ready = (q_cnt_q + 3'(s2_v)) <= 3'd3;
	assign acc = in_ch.valid && in_ch.ready;

	// Stage 1 result, before memory data is merged.
	logic       r_v, r_mem;
	logic [1:0] r_dest;
	logic [7:0] r_data;
	logic       r_st, r_be;
	logic [8:0] r_cnt;
	logic       rd_en;
	logic [AW-1:0] rd_addr;

	// Next-state values.
	phase_t        n_phase;
	logic [LW-1:0] n_len, n_sent;
	logic          n_seq, n_more;
	logic [8:0]    n_txp, n_rxp, n_resp;
	logic [7:0]    n_txl, n_pcb, n_info, n_lrc, n_rpcb, n_rlen, n_rfirst;
	logic          wr_en;

	logic [CW-1:0] rem, ifs, sent_adv, idx;
	logic [7:0]    d;
	logic [7:0]    rtype;
	logic          prep;
	logic [LW-1:0] prep_sent;
	logic          prep_seq;

	// Memory byte still in stage 2, not yet in the running LRC.
	logic mem_lrc_s2;
	logic [7:0] lrc_fix;

	always_comb begin
		n_phase = phase_q; n_len = cmd_len_q; n_sent = cmd_sent_q; n_seq = seq_q;
		n_more = more_q; n_txp = tx_pos_q; n_rxp = rx_pos_q; n_resp = resp_q;
		n_txl = tx_len_q; n_pcb = tx_pcb_q; n_info = tx_info_q; n_lrc = tx_lrc_q;
		n_rpcb = rx_pcb_q; n_rlen = rx_len_q; n_rfirst = rx_first_q;
		r_v = 1'b0; r_mem = 1'b0; r_dest = DEST_CARD; r_data = '0; r_st = 1'b0;
		r_be = 1'b0; r_cnt = '0; rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0;
		prep = 1'b0; prep_sent = cmd_sent_q; prep_seq = seq_q;
		d = in_ch.data;
		rtype = rx_pcb_q[7] ? (rx_pcb_q & TYPE_MASK) : 8'h00;
		idx = '0;
		if (acc) begin
			case (in_ch.action)
				ACT_CMD: begin
					if (phase_q == PH_IDLE) begin
						if (CW'(cmd_len_q) < CW'(CMD_DEPTH)) begin
							wr_en = 1'b1;
							n_len = cmd_len_q + LW'(1);
						end
						if (in_ch.last) begin
							n_resp = '0;
							prep = 1'b1;
							prep_sent = '0;
							prep_seq = ~seq_q;
							n_seq = ~seq_q;
						end
					end
				end
				ACT_CARD: begin
					if (phase_q == PH_WAIT_R || phase_q == PH_RX || phase_q == PH_WAIT_S) begin
						n_rxp = rx_pos_q + 9'd1;
						if (rx_pos_q == 9'd1) n_rpcb = d;
						if (rx_pos_q == 9'd2) begin
							n_rlen = d;
							if (phase_q == PH_RX && !rx_pcb_q[7] &&
									(13'(resp_q) + 13'(d)) > 13'(RESP_MAX)) begin
								r_v = 1'b1; r_dest = DEST_END; r_st = 1'b1; r_cnt = resp_q;
								n_phase = PH_IDLE; n_len = '0; n_sent = '0; n_rxp = '0;
							end
						end else if (rx_pos_q >= 9'd3) begin
							if (rx_pos_q == 9'd3) n_rfirst = d;
							if (rx_pos_q == 9'd3 + 9'(rx_len_q)) begin
								// Block complete.
								n_rxp = '0;
								if (phase_q == PH_WAIT_R) begin
									if (rtype != TYPE_R_OK) begin
										r_v = 1'b1; r_dest = DEST_END; r_st = 1'b1;
									end else begin
										n_seq = ~seq_q;
										prep = 1'b1;
										prep_seq = ~seq_q;
										prep_sent = cmd_sent_q + LW'(tx_len_q);
										n_sent = prep_sent;
									end
								end else if (phase_q == PH_WAIT_S) begin
									if (tx_pcb_q == PCB_RESYN_REQ && rtype == TYPE_RESYN_RSP)
										n_seq = 1'b0;
									r_v = 1'b1; r_dest = DEST_END;
								end else if (rtype == 8'h00) begin
									if (rx_pcb_q[5]) begin
										n_pcb = {3'b100, ~rx_pcb_q[6], 4'b0000};
										n_txl = '0; n_info = '0; n_txp = '0; n_lrc = '0;
										n_phase = PH_TX_R;
									end else begin
										r_v = 1'b1; r_dest = DEST_END;
									end
								end else if (rtype == TYPE_WTX_REQ) begin
									n_pcb = PCB_WTX_RSP; n_txl = 8'd1;
									n_info = (rx_pos_q == 9'd3) ? d : rx_first_q;
									n_txp = '0; n_lrc = '0; n_phase = PH_TX_R;
								end else begin
									r_v = 1'b1; r_dest = DEST_END; r_st = 1'b1;
								end
								if (r_v) begin
									r_cnt = resp_q;
									n_phase = PH_IDLE; n_len = '0; n_sent = '0;
								end
							end else if (phase_q == PH_RX && !rx_pcb_q[7]) begin
								n_resp = resp_q + 9'd1;
								r_v = 1'b1; r_dest = DEST_HOST; r_data = d;
							end
						end
					end
				end
				ACT_TIMEOUT: begin
					if (phase_q != PH_IDLE) begin
						r_v = 1'b1; r_dest = DEST_END; r_st = 1'b1; r_cnt = resp_q;
						n_phase = PH_IDLE; n_len = '0; n_sent = '0; n_rxp = '0;
					end
				end
				ACT_IFS, ACT_RESYNCH: begin
					if (phase_q == PH_IDLE) begin
						n_resp = '0;
						n_pcb = (in_ch.action == ACT_IFS) ? PCB_IFS_REQ : PCB_RESYN_REQ;
						n_txl = (in_ch.action == ACT_IFS) ? 8'd1 : 8'd0;
						n_info = (in_ch.action == ACT_IFS) ? d : 8'd0;
						n_txp = '0; n_lrc = '0; n_phase = PH_TX_S;
					end
				end
				ACT_SLOT: begin
					if (phase_q == PH_TX_I || phase_q == PH_TX_R || phase_q == PH_TX_S) begin
						r_v = 1'b1; r_dest = DEST_CARD;
						if (tx_pos_q == 9'd3 + 9'(tx_len_q)) begin
							// A memory byte of the previous slot may still be in stage 2.
							r_data = tx_lrc_q ^ (mem_lrc_s2 ? lrc_fix : 8'h00);
							r_be = 1'b1;
							n_phase = (phase_q == PH_TX_I) ? (more_q ? PH_WAIT_R : PH_RX)
								: (phase_q == PH_TX_R) ? PH_RX : PH_WAIT_S;
							n_txp = '0; n_rxp = '0;
						end else begin
							n_txp = tx_pos_q + 9'd1;
							if (tx_pos_q == 9'd0) r_data = 8'h00;
							else if (tx_pos_q == 9'd1) r_data = tx_pcb_q;
							else if (tx_pos_q == 9'd2) r_data = tx_len_q;
							else if (tx_pcb_q[7]) r_data = tx_info_q;
							else begin
								idx = CW'(cmd_sent_q) + CW'(tx_pos_q) - CW'(3);
								if (idx < CW'(CMD_DEPTH)) begin
									r_mem = 1'b1; rd_en = 1'b1; rd_addr = idx[AW-1:0];
								end
							end
							// LRC of memory bytes is folded in stage 2.
							if (!r_mem) n_lrc = tx_lrc_q ^ r_data;
						end
					end
				end
				default: ;
			endcase
		end
		// Split the command into the next I-block.
		rem = CW'(n_len) - CW'(prep_sent);
		ifs = (ifsc_q == 8'd0) ? CW'(1) : CW'(ifsc_q);
		sent_adv = (rem < ifs) ? rem : ifs;
		if (prep) begin
			n_more = rem > ifs;
			n_pcb = {1'b0, prep_seq, rem > ifs, 5'b0};
			n_txl = sent_adv[7:0]; n_info = '0; n_txp = '0; n_lrc = '0;
			n_phase = PH_TX_I;
		end
	end

	// Stage 1 registers: control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; cmd_len_q <= '0; cmd_sent_q <= '0; seq_q <= 1'b1;
			more_q <= 1'b0; tx_pos_q <= '0; rx_pos_q <= '0; resp_q <= '0;
			tx_len_q <= '0; tx_pcb_q <= '0; tx_info_q <= '0; tx_lrc_q <= '0;
			rx_pcb_q <= '0; rx_len_q <= '0; rx_first_q <= '0;
		end else begin
			phase_q <= n_phase; cmd_len_q <= n_len; cmd_sent_q <= n_sent; seq_q <= n_seq;
			more_q <= n_more; tx_pos_q <= n_txp; rx_pos_q <= n_rxp; resp_q <= n_resp;
			tx_len_q <= n_txl; tx_pcb_q <= n_pcb; tx_info_q <= n_info;
			rx_pcb_q <= n_rpcb; rx_len_q <= n_rlen; rx_first_q <= n_rfirst;
			// Forward the memory byte of stage 2 into the running LRC.
			tx_lrc_q <= (mem_lrc_s2 && !(n_txp == '0)) ? (n_lrc ^ lrc_fix) : n_lrc;
		end
	end

	// Command memory: one write port, one registered read port.
	logic [7:0] rd_data_s2;
	always_ff @(posedge clk) begin
		if (wr_en) mem[cmd_len_q[AW-1:0]] <= in_ch.data;
		if (rd_en) rd_data_s2 <= mem[rd_addr];
	end

	// Stage 2 registers.
	logic       mem_s2;
	logic [1:0] dest_s2;
	logic [7:0] data_s2;
	logic       st_s2, be_s2;
	logic [8:0] cnt_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0; mem_s2 <= 1'b0;
		end else begin
			s2_v <= r_v; mem_s2 <= r_mem;
		end
	end
	always_ff @(posedge clk) begin
		dest_s2 <= r_dest; data_s2 <= r_data; st_s2 <= r_st; be_s2 <= r_be; cnt_s2 <= r_cnt;
	end
	assign mem_lrc_s2 = s2_v && mem_s2;
	assign lrc_fix = rd_data_s2;

	// Output queue, four entries.
	typedef struct packed {
		logic [1:0] dest;
		logic [7:0] data;
		logic       st;
		logic [8:0] cnt;
		logic       be;
	} res_t;
	res_t q_q [4];
	res_t s2_res;
	logic push, pop;
	logic [1:0] rd_ptr_q, wr_ptr_q;
	always_comb begin
		s2_res.dest = dest_s2;
		s2_res.data = mem_s2 ? rd_data_s2 : data_s2;
		s2_res.st = st_s2; s2_res.cnt = cnt_s2; s2_res.be = be_s2;
	end
	assign push = s2_v;
	assign pop = out_ch.valid && out_ch.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0; rd_ptr_q <= '0; wr_ptr_q <= '0;
		end else begin
			q_cnt_q <= q_cnt_q + 3'(push) - 3'(pop);
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (push) q_q[wr_ptr_q] <= s2_res;
	end
	assign out_ch.valid = q_cnt_q != 3'd0;
	assign out_ch.dest = q_q[rd_ptr_q].dest;
	assign out_ch.data_res = q_q[rd_ptr_q].data;
	assign out_ch.status = q_q[rd_ptr_q].st;
	assign out_ch.resp_count = q_q[rd_ptr_q].cnt;
	assign out_ch.block_end = q_q[rd_ptr_q].be;

`ifndef NO_ASSERTIONS
	// The queue never holds more than four results.
	a_qcnt: assert property (@(posedge clk) disable iff (!arst_n)
		q_cnt_q <= 3'd4) else $error("output queue overflow");
	// A stage 2 result always finds room in the queue.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		s2_v |-> (q_cnt_q != 3'd4 || pop)) else $error("result dropped");
	// Memory reads only come from I-block transmission.
	a_rd: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> phase_q == PH_TX_I) else $error("stray memory read");
`endif

endmodule

// File: bench/iso7816_t1_block_engine_tb.sv
// Self-checking testbench for the T=1 block engine: a directed table, then random traffic.
// Depends on t1be_pkg, the channel interfaces in t1be_if.sv and the top level.
module iso7816_t1_block_engine_tb;
	import t1be_pkg::*;

	localparam int STORE_DEPTH = 512;
	localparam int RESP_LIMIT = 259;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_GOAL = 1650;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;

	// Kinds of rows in the directed table.
	localparam logic [1:0] ROW_PREDICT = 2'd0;
	localparam logic [1:0] ROW_RESULT = 2'd1;
	localparam logic [1:0] ROW_SILENT = 2'd2;

	typedef struct packed {
		logic [1:0] dest;
		logic [7:0] data_res;
		logic       status;
		logic [8:0] resp_count;
		logic       block_end;
	} t1_res_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] action;
		logic [7:0] data;
		logic       last;
		t1_res_t    res;
	} dir_row_t;

	logic clk;
	logic arst_n;

	t1be_in_if in_ch();
	t1be_out_if out_ch();
	t1be_cfg_if cfg_ch();

	iso7816_t1_block_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	// Clock with a period of two time units.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow state of the engine, kept by the predictor.
	phase_t      m_phase;
	logic [7:0]  m_store [STORE_DEPTH];
	int unsigned m_cmd_len, m_cmd_sent, m_tx_pos, m_rx_pos, m_resp_total;
	logic        m_seq, m_more;
	logic [7:0]  m_tx_len, m_tx_pcb, m_tx_info, m_tx_lrc;
	logic [7:0]  m_rx_pcb, m_rx_len, m_rx_first;
	logic [7:0]  m_ifsc;

	t1_res_t     pending_q [$];
	int          errors = 0;
	int          cycles = 0;
	int          hold_asked = 0;

	function automatic t1_res_t make_res(logic [1:0] dest, logic [7:0] b, logic st,
			logic [8:0] cnt, logic be);
		t1_res_t r;
		r.dest = dest;
		r.data_res = b;
		r.status = st;
		r.resp_count = cnt;
		r.block_end = be;
		return r;
	endfunction

	// End of a transaction: back to idle with the response count.
	function automatic t1_res_t close_txn(logic err);
		m_phase = PH_IDLE;
		m_cmd_len = 0;
		m_cmd_sent = 0;
		m_rx_pos = 0;
		return make_res(DEST_END, 8'h00, err, m_resp_total[8:0], 1'b0);
	endfunction

	function automatic void load_block(logic [7:0] pcb, logic [7:0] len, logic [7:0] info,
			phase_t ph);
		m_tx_pcb = pcb;
		m_tx_len = len;
		m_tx_info = info;
		m_tx_pos = 0;
		m_tx_lrc = 8'h00;
		m_phase = ph;
	endfunction

	// Cut the next I-block from the stored command.
	function automatic void next_iblock();
		int unsigned rem, ifs, n;
		rem = m_cmd_len - m_cmd_sent;
		ifs = (m_ifsc == 0) ? 1 : m_ifsc;
		n = (rem < ifs) ? rem : ifs;
		m_more = (rem > ifs);
		load_block({1'b0, m_seq, m_more, 5'b0}, n[7:0], 8'h00, PH_TX_I);
	endfunction

	// A received block is complete: decide what follows.
	function automatic logic block_done(output t1_res_t r);
		logic [7:0] kind;
		kind = m_rx_pcb[7] ? (m_rx_pcb & TYPE_MASK) : 8'h00;
		m_rx_pos = 0;
		if (m_phase == PH_WAIT_R) begin
			if (kind != TYPE_R_OK) begin
				r = close_txn(1'b1);
				return 1'b1;
			end
			m_seq ^= 1'b1;
			m_cmd_sent += m_tx_len;
			next_iblock();
			return 1'b0;
		end
		if (m_phase == PH_WAIT_S) begin
			if (m_tx_pcb == PCB_RESYN_REQ && kind == TYPE_RESYN_RSP)
				m_seq = 1'b0;
			r = close_txn(1'b0);
			return 1'b1;
		end
		if (kind == 8'h00) begin
			// A chained card block is acknowledged with the opposite sequence number.
			if (m_rx_pcb[5]) begin
				load_block(TYPE_R_OK | {3'b0, ~m_rx_pcb[6], 4'b0}, 8'h00, 8'h00, PH_TX_R);
				return 1'b0;
			end
			r = close_txn(1'b0);
			return 1'b1;
		end
		if (kind == TYPE_WTX_REQ) begin
			load_block(PCB_WTX_RSP, 8'd1, m_rx_first, PH_TX_R);
			return 1'b0;
		end
		r = close_txn(1'b1);
		return 1'b1;
	endfunction

	function automatic logic card_byte(logic [7:0] d, output t1_res_t r);
		int unsigned pos;
		if (m_phase != PH_WAIT_R && m_phase != PH_RX && m_phase != PH_WAIT_S)
			return 1'b0;
		pos = m_rx_pos;
		m_rx_pos = pos + 1;
		if (pos == 1)
			m_rx_pcb = d;
		if (pos == 2) begin
			m_rx_len = d;
			if (m_phase == PH_RX && !m_rx_pcb[7] && m_resp_total + d > RESP_LIMIT) begin
				r = close_txn(1'b1);
				return 1'b1;
			end
			return 1'b0;
		end
		if (pos < 3)
			return 1'b0;
		if (pos == 3)
			m_rx_first = d;
		if (pos == 3 + m_rx_len)
			return block_done(r);
		if (m_phase == PH_RX && !m_rx_pcb[7]) begin
			m_resp_total++;
			r = make_res(DEST_HOST, d, 1'b0, 9'd0, 1'b0);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic slot_byte(output t1_res_t r);
		int unsigned idx;
		logic [7:0] b;
		if (m_phase != PH_TX_I && m_phase != PH_TX_R && m_phase != PH_TX_S)
			return 1'b0;
		// The LRC closes the block and hands over to the receive side.
		if (m_tx_pos == 3 + m_tx_len) begin
			if (m_phase == PH_TX_I)
				m_phase = m_more ? PH_WAIT_R : PH_RX;
			else if (m_phase == PH_TX_R)
				m_phase = PH_RX;
			else
				m_phase = PH_WAIT_S;
			m_tx_pos = 0;
			m_rx_pos = 0;
			r = make_res(DEST_CARD, m_tx_lrc, 1'b0, 9'd0, 1'b1);
			return 1'b1;
		end
		if (m_tx_pos == 0)
			b = 8'h00;
		else if (m_tx_pos == 1)
			b = m_tx_pcb;
		else if (m_tx_pos == 2)
			b = m_tx_len;
		else if (m_tx_pcb[7])
			b = m_tx_info;
		else begin
			idx = m_cmd_sent + m_tx_pos - 3;
			b = (idx < STORE_DEPTH) ? m_store[idx] : 8'h00;
		end
		m_tx_lrc ^= b;
		m_tx_pos++;
		r = make_res(DEST_CARD, b, 1'b0, 9'd0, 1'b0);
		return 1'b1;
	endfunction

	// Predictor: one input transaction in, at most one result out.
	function automatic logic engine_step(logic [2:0] act, logic [7:0] d, logic l,
			output t1_res_t r);
		case (act)
			ACT_CMD: begin
				if (m_phase != PH_IDLE)
					return 1'b0;
				if (m_cmd_len < STORE_DEPTH) begin
					m_store[m_cmd_len] = d;
					m_cmd_len++;
				end
				if (l) begin
					m_resp_total = 0;
					m_cmd_sent = 0;
					m_seq ^= 1'b1;
					next_iblock();
				end
				return 1'b0;
			end
			ACT_CARD: return card_byte(d, r);
			ACT_TIMEOUT: begin
				if (m_phase == PH_IDLE)
					return 1'b0;
				r = close_txn(1'b1);
				return 1'b1;
			end
			ACT_IFS: begin
				if (m_phase != PH_IDLE)
					return 1'b0;
				m_resp_total = 0;
				load_block(PCB_IFS_REQ, 8'd1, d, PH_TX_S);
				return 1'b0;
			end
			ACT_RESYNCH: begin
				if (m_phase != PH_IDLE)
					return 1'b0;
				m_resp_total = 0;
				load_block(PCB_RESYN_REQ, 8'd0, 8'h00, PH_TX_S);
				return 1'b0;
			end
			ACT_SLOT: return slot_byte(r);
			default: return 1'b0;
		endcase
	endfunction

	// Receiver: random ready patterns, plus long hold-offs on request.
	int hold_seen = 0;
	int hold_left = 0;
	int ready_mode = 0;
	int mode_left = 0;
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ch.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0: out_ch.ready <= 1'b1;
				1: out_ch.ready <= $urandom_range(0, 1);
				2: out_ch.ready <= ($urandom_range(0, 3) == 0);
				default: out_ch.ready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// Result checker against the oldest expectation.
	always @(posedge clk) begin : result_check
		t1_res_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result: dest %0d data_res %0h", out_ch.dest, out_ch.data_res);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (out_ch.dest !== e.dest) begin
					$error("dest: expected %0d, actual %0d", e.dest, out_ch.dest);
					errors++;
				end
				if (out_ch.data_res !== e.data_res) begin
					$error("data_res: expected %0h, actual %0h", e.data_res, out_ch.data_res);
					errors++;
				end
				if (out_ch.status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, out_ch.status);
					errors++;
				end
				if (out_ch.resp_count !== e.resp_count) begin
					$error("resp_count: expected %0d, actual %0d", e.resp_count,
						out_ch.resp_count);
					errors++;
				end
				if (out_ch.block_end !== e.block_end) begin
					$error("block_end: expected %0d, actual %0d", e.block_end,
						out_ch.block_end);
					errors++;
				end
			end
		end
	end

	// Watchdog on the cycle count.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("iso7816_t1_block_engine_tb: done, errors");
			$finish;
		end
	end

	// Sender: bursts of transactions with random gaps in between.
	int burst_left = 0;
	task automatic drive_item(input logic [2:0] act, input logic [7:0] d, input logic l);
		in_ch.valid <= 1'b1;
		in_ch.action <= act;
		in_ch.data <= d;
		in_ch.last <= l;
		do @(posedge clk); while (!in_ch.ready);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end else begin
			burst_left--;
		end
	endtask

	task automatic predict_and_drive(input logic [2:0] act, input logic [7:0] d,
			input logic l);
		t1_res_t r;
		if (engine_step(act, d, l, r))
			pending_q.push_back(r);
		drive_item(act, d, l);
	endtask

	// Stop sending until every expected result is back and the engine has settled.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ifsc(input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		m_ifsc = v;
		cfg_ch.valid <= 1'b0;
	endtask

	// Choose the next card byte so that most blocks are well formed.
	function automatic logic [7:0] pick_card_byte();
		int unsigned room, pick;
		pick = $urandom_range(0, 99);
		if (m_rx_pos == 1) begin
			if (m_phase == PH_WAIT_R)
				return (pick < 80) ? (TYPE_R_OK | {3'b0, 1'($urandom_range(0, 1)), 4'b0})
					: 8'($urandom);
			if (m_phase == PH_RX) begin
				if (pick < 70)
					return {1'b0, 1'($urandom_range(0, 1)), ($urandom_range(0, 9) < 3),
						5'($urandom)};
				if (pick < 85)
					return TYPE_WTX_REQ | {3'b0, 1'($urandom_range(0, 1)), 4'b0};
				return 8'($urandom);
			end
			return (pick < 70) ? (TYPE_RESYN_RSP | {7'b0, 1'($urandom_range(0, 1))})
				: 8'($urandom);
		end
		if (m_rx_pos == 2) begin
			if (m_phase == PH_RX && !m_rx_pcb[7]) begin
				room = RESP_LIMIT - m_resp_total;
				if (pick < 88)
					return 8'($urandom_range(0, (room < 12) ? room : 12));
				if (pick < 94)
					return 8'($urandom_range(0, 255));
				return (room < 255) ? 8'(room + 1) : 8'd255;
			end
			return (pick < 85) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 3));
		end
		return 8'($urandom);
	endfunction

	int cmd_target = 0;
	int cmd_count = 0;

	// One random transaction, shaped by the predicted phase.
	task automatic random_item(output logic counted);
		logic [2:0] act;
		logic [7:0] d;
		logic l;
		int pick;
		pick = $urandom_range(0, 99);
		counted = 1'b1;
		d = 8'($urandom);
		l = 1'b0;
		if (pick < 2) begin
			act = 3'($urandom_range(0, 5));
			l = 1'($urandom_range(0, 1));
			counted = 1'b0;
		end else if (m_phase == PH_IDLE) begin
			pick = $urandom_range(0, 99);
			if ((cmd_count == 0 && pick < 8) || (cmd_count != 0 && pick < 1))
				act = ACT_IFS;
			else if ((cmd_count == 0 && pick < 16) || (cmd_count != 0 && pick < 2))
				act = ACT_RESYNCH;
			else begin
				if (cmd_count == 0) begin
					pick = $urandom_range(0, 99);
					if (pick < 85 || m_ifsc < 16)
						cmd_target = $urandom_range(1, 24);
					else if (pick < 95)
						cmd_target = $urandom_range(25, 120);
					else if (pick < 99 || m_ifsc < 64)
						cmd_target = $urandom_range(200, 300);
					else
						cmd_target = $urandom_range(513, 530);
				end
				act = ACT_CMD;
				cmd_count++;
				if (cmd_count >= cmd_target) begin
					l = 1'b1;
					cmd_count = 0;
				end
			end
		end else if (pick < 3) begin
			act = ACT_TIMEOUT;
		end else if (m_phase == PH_TX_I || m_phase == PH_TX_R || m_phase == PH_TX_S) begin
			act = ACT_SLOT;
		end else begin
			act = ACT_CARD;
			d = pick_card_byte();
		end
		predict_and_drive(act, d, l);
	endtask

	// Directed rows: IFS request and reply, resynch and reply, then a command cut
	// short by a timeout, with idle-time strays that must be ignored.
	dir_row_t dir_rows [0:25] = '{
		'{ROW_SILENT, ACT_IFS, 8'hFE, 1'b0, '0},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h00, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, PCB_IFS_REQ, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h01, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'hFE, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h3E, 1'b0, 9'd0, 1'b1}},
		'{ROW_PREDICT, ACT_CARD, 8'h00, 1'b0, '0},
		'{ROW_PREDICT, ACT_CARD, 8'hE1, 1'b0, '0},
		'{ROW_PREDICT, ACT_CARD, 8'h01, 1'b0, '0},
		'{ROW_PREDICT, ACT_CARD, 8'h20, 1'b0, '0},
		'{ROW_RESULT, ACT_CARD, 8'hC0, 1'b0, '{DEST_END, 8'h00, 1'b0, 9'd0, 1'b0}},
		'{ROW_SILENT, ACT_RESYNCH, 8'h00, 1'b0, '0},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h00, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, PCB_RESYN_REQ, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h00, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, PCB_RESYN_REQ, 1'b0, 9'd0, 1'b1}},
		'{ROW_PREDICT, ACT_CARD, 8'h00, 1'b0, '0},
		'{ROW_PREDICT, ACT_CARD, TYPE_RESYN_RSP, 1'b0, '0},
		'{ROW_PREDICT, ACT_CARD, 8'h00, 1'b0, '0},
		'{ROW_RESULT, ACT_CARD, 8'hFF, 1'b0, '{DEST_END, 8'h00, 1'b0, 9'd0, 1'b0}},
		'{ROW_SILENT, ACT_TIMEOUT, 8'h00, 1'b0, '0},
		'{ROW_SILENT, ACT_CMD, 8'hFF, 1'b1, '0},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h00, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_SLOT, 8'h00, 1'b0, '{DEST_CARD, 8'h40, 1'b0, 9'd0, 1'b0}},
		'{ROW_RESULT, ACT_TIMEOUT, 8'h00, 1'b0, '{DEST_END, 8'h00, 1'b1, 9'd0, 1'b0}},
		'{ROW_SILENT, ACT_SLOT, 8'h00, 1'b0, '0}
	};

	// Main sequence: reset, directed table, random traffic, drain and verdict.
	initial begin : stimulus
		t1_res_t r;
		logic counted;
		int items;
		int cfg_writes;
		logic [7:0] ifsc_val;
		items = 0;
		cfg_writes = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_CMD;
		in_ch.data = 8'h00;
		in_ch.last = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = 8'h00;
		out_ch.ready = 1'b0;
		m_phase = PH_IDLE;
		m_cmd_len = 0;
		m_cmd_sent = 0;
		m_tx_pos = 0;
		m_rx_pos = 0;
		m_resp_total = 0;
		m_seq = 1'b1;
		m_more = 1'b0;
		m_tx_len = 8'h00;
		m_tx_pcb = 8'h00;
		m_tx_info = 8'h00;
		m_tx_lrc = 8'h00;
		m_rx_pcb = 8'h00;
		m_rx_len = 8'h00;
		m_rx_first = 8'h00;
		m_ifsc = IFSC_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the register at its reset value.
		foreach (dir_rows[i]) begin
			if (engine_step(dir_rows[i].action, dir_rows[i].data, dir_rows[i].last, r)
					&& dir_rows[i].kind == ROW_PREDICT)
				pending_q.push_back(r);
			if (dir_rows[i].kind == ROW_RESULT)
				pending_q.push_back(dir_rows[i].res);
			drive_item(dir_rows[i].action, dir_rows[i].data, dir_rows[i].last);
		end

		// Random part: whole transactions, the register changed between some of them.
		while (!(items >= ITEM_GOAL && m_phase == PH_IDLE && m_cmd_len == 0)) begin
			if (m_phase == PH_IDLE && m_cmd_len == 0 && cmd_count == 0
					&& (items == 0 || $urandom_range(0, 11) == 0)) begin
				drain_results();
				case (cfg_writes % 5)
					0: ifsc_val = 8'd1;
					1: ifsc_val = 8'd254;
					2: ifsc_val = 8'd4;
					3: ifsc_val = IFSC_RESET;
					default: ifsc_val = 8'($urandom_range(1, 254));
				endcase
				write_ifsc(ifsc_val);
				cfg_writes++;
			end
			if ((items == 400 || items == 1200) && hold_seen == hold_asked)
				hold_asked <= hold_asked + 1;
			random_item(counted);
			if (counted)
				items++;
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("iso7816_t1_block_engine_tb: done, clean");
		else
			$display("iso7816_t1_block_engine_tb: done, errors");
		$finish;
	end

endmodule

// File: sim.f
design/t1be_pkg.sv
design/t1be_if.sv
design/iso7816_t1_block_engine.sv
bench/iso7816_t1_block_engine_tb.sv
